/* hw/rtl/dpsp_pkg.sv */
// Shared types, constants and register codes for the dual pedal sensor plausibility block.
package dpsp_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned RAW_W        = 12;
  localparam int unsigned MV_W         = 12;
  localparam int unsigned CAL_W        = 13;
  localparam int unsigned PM_W         = 10;
  localparam int unsigned NUM_W        = MV_W + PM_W;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = CAL_W;

  localparam int unsigned CONV_STAGES  = 3;
  localparam int unsigned ST_PREP      = CONV_STAGES;
  localparam int unsigned ST_DIV0      = ST_PREP + 1;
  localparam int unsigned DIV_STAGES   = PM_W;
  localparam int unsigned ST_OUT       = ST_DIV0 + DIV_STAGES;
  localparam int unsigned PIPE_STAGES  = ST_OUT + 1;
  localparam int unsigned SIDE_N       = DIV_STAGES + 1;

  localparam logic [MV_W-1:0]  REF_MV           = 12'd3300;
  localparam logic [CAL_W-1:0] GND_LIM_FIRST    = 13'd500;
  localparam logic [CAL_W-1:0] GND_LIM_SECOND   = 13'd250;
  localparam logic [CAL_W-1:0] SUP_LIM_FIRST    = 13'd4500;
  localparam logic [CAL_W-1:0] SUP_LIM_SECOND   = 13'd2250;
  localparam logic [PM_W-1:0]  PERMILLE_FULL    = 10'd1000;

  localparam logic [CAL_W-1:0] RST_CAL_LOW_FIRST   = 13'd600;
  localparam logic [CAL_W-1:0] RST_CAL_HIGH_FIRST  = 13'd4400;
  localparam logic [CAL_W-1:0] RST_CAL_LOW_SECOND  = 13'd350;
  localparam logic [CAL_W-1:0] RST_CAL_HIGH_SECOND = 13'd2150;
  localparam logic [CAL_W-1:0] RST_MIN_CHANNEL_GAP = 13'd30;
  localparam logic [PM_W-1:0]  RST_MAX_PERCENT_GAP = 10'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_LOW_FIRST   = 3'd0,
    REG_CAL_HIGH_FIRST  = 3'd1,
    REG_CAL_LOW_SECOND  = 3'd2,
    REG_CAL_HIGH_SECOND = 3'd3,
    REG_MIN_CHANNEL_GAP = 3'd4,
    REG_MAX_PERCENT_GAP = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PM_DIV,
    PM_ZERO,
    PM_FULL
  } pm_sel_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_first;
    logic [RAW_W-1:0] raw_second;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0] millivolts_first;
    logic [MV_W-1:0] millivolts_second;
    logic [PM_W-1:0] permille_first;
    logic [PM_W-1:0] permille_second;
    logic [PM_W-1:0] pedal_position;
    logic            plausible;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0] mv_first;
    logic [MV_W-1:0] mv_second;
    pm_sel_t         sel_first;
    pm_sel_t         sel_second;
    logic            ok;
  } side_t;

endpackage

/* hw/rtl/dpsp_pipe_ctl.sv */
// Valid tracking and per-stage load enables for the pipeline, with bubble collapsing.
module dpsp_pipe_ctl #(
  parameter int unsigned STAGES = dpsp_pkg::PIPE_STAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output logic [STAGES-1:0] stage_en
);
  import dpsp_pkg::*;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] valid_in;

  // A stage may load when the output drains or some stage at or after it is empty.
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      stage_en[k] = !out_stall ||
                    ((valid_r | STAGES'((64'd1 << k) - 64'd1)) != {STAGES{1'b1}});
    end
  end

  assign valid_in = {valid_r[STAGES-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      valid_nxt[k] = stage_en[k] ? valid_in[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = valid_r[STAGES-1];

endmodule

/* hw/rtl/dpsp_mv_conv.sv */
// Three-stage conversion of a converter code to millivolts by division by the full-scale code.
module dpsp_mv_conv #(
  parameter int unsigned ADC_BITS = dpsp_pkg::ADC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic [dpsp_pkg::CONV_STAGES-1:0]         stage_en,
  input  logic [dpsp_pkg::RAW_W-1:0]               raw,
  output logic [dpsp_pkg::MV_W-1:0]                mv
);
  import dpsp_pkg::*;

  localparam int unsigned XW = ADC_BITS + MV_W;
  localparam int unsigned RW = ((ADC_BITS > MV_W) ? ADC_BITS : MV_W) + 1;
  localparam int unsigned FW = ADC_BITS + 1;
  localparam logic [FW-1:0] FULL_SCALE = FW'((64'd1 << ADC_BITS) - 64'd1);

  logic [ADC_BITS-1:0] code;
  logic [XW-1:0]       x_r;
  logic [XW-1:0]       x_nxt;
  logic [MV_W-1:0]     q0;
  logic [RW-1:0]       r0;
  logic [RW-1:0]       r0_hi;
  logic [MV_W-1:0]     q1_r;
  logic [MV_W-1:0]     q1_nxt;
  logic [FW-1:0]       r1_r;
  logic [FW-1:0]       r1_nxt;
  logic [MV_W-1:0]     mv_r;
  logic [MV_W-1:0]     mv_nxt;

  assign code  = ADC_BITS'(raw);
  assign x_nxt = XW'(code) * XW'(REF_MV);

  // The product is folded twice by the identity 2^N = (2^N - 1) + 1.
  assign q0     = MV_W'(x_r >> ADC_BITS);
  assign r0     = RW'(x_r[ADC_BITS-1:0]) + RW'(q0);
  assign r0_hi  = r0 >> ADC_BITS;
  assign q1_nxt = q0 + MV_W'(r0_hi);
  assign r1_nxt = FW'(r0[ADC_BITS-1:0]) + FW'(r0_hi);

  assign mv_nxt = q1_r + MV_W'(r1_r >= FULL_SCALE);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_r <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q1_r <= q1_nxt;
      r1_r <= r1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      mv_r <= mv_nxt;
    end
  end

  assign mv = mv_r;

endmodule

/* hw/rtl/dpsp_div.sv */
// Pipelined restoring divider that settles one quotient bit per stage.
module dpsp_div #(
  parameter int unsigned NUM_W = dpsp_pkg::NUM_W,
  parameter int unsigned DEN_W = dpsp_pkg::CAL_W,
  parameter int unsigned Q_W   = dpsp_pkg::DIV_STAGES
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   stage_en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);
  import dpsp_pkg::*;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W-1];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (i == 0) begin : g_head
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_body
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = {1'b0, rem_in} - ((NUM_W+1)'(den_in) << (Q_W - 1 - i));

    always_comb begin
      if (!trial[NUM_W]) begin
        rem_nxt = trial[NUM_W-1:0];
        q_nxt   = q_in | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[i]) begin
        rem_r[i] <= rem_nxt;
        q_r[i]   <= q_nxt;
      end
    end

    if (i < Q_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (stage_en[i]) begin
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quot = q_r[Q_W-1];

endmodule

/* hw/rtl/dual_pedal_sensor_plausibility.sv */
// Top level of the dual pedal sensor plausibility block.
// The block takes one pair of sensor codes per clock while in_stall is low and returns one
// result item per pair. Three stages convert each code to millivolts, one stage checks the
// voltages and sets up the per-mille division, ten stages of a restoring divider per channel
// each settle one quotient bit, and a final stage forms the average and the plausibility
// flag. Each stage loads whenever it or a later stage is empty, so the input keeps flowing
// while a finished result waits. Calibration registers are written through a plain write
// port and must be changed only while the pipeline is empty.
module dual_pedal_sensor_plausibility #(
  parameter int unsigned ADC_BITS = dpsp_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dpsp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dpsp_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [dpsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dpsp_pkg::*;

  typedef struct packed {
    pm_sel_t          sel;
    logic [NUM_W-1:0] num;
    logic [CAL_W-1:0] den;
    logic             window_bad;
  } prep_t;

  function automatic prep_t chan_prep(input logic [MV_W-1:0] mv,
                                      input logic [CAL_W-1:0] lo,
                                      input logic [CAL_W-1:0] hi);
    prep_t            p;
    logic [CAL_W-1:0] mvx;
    logic [MV_W-1:0]  diff;
    mvx   = CAL_W'(mv);
    diff  = MV_W'(mvx - lo);
    p.num = NUM_W'(diff) * NUM_W'(PERMILLE_FULL);
    p.den = hi - lo;
    priority if (hi <= lo || mvx <= lo) begin
      p.sel = PM_ZERO;
    end else if (mvx >= hi) begin
      p.sel = PM_FULL;
    end else begin
      p.sel = PM_DIV;
    end
    p.window_bad = (mvx < lo) || (mvx > hi);
    return p;
  endfunction

  logic [CAL_W-1:0] cal_low_first_r;
  logic [CAL_W-1:0] cal_high_first_r;
  logic [CAL_W-1:0] cal_low_second_r;
  logic [CAL_W-1:0] cal_high_second_r;
  logic [CAL_W-1:0] min_channel_gap_r;
  logic [PM_W-1:0]  max_percent_gap_r;

  logic [PIPE_STAGES-1:0] stage_en;
  logic [MV_W-1:0]        mv_first;
  logic [MV_W-1:0]        mv_second;
  prep_t                  prep_first;
  prep_t                  prep_second;
  logic [MV_W-1:0]        mv_dist;
  side_t                  side_nxt;
  side_t                  side_r [SIDE_N];
  logic [NUM_W-1:0]       num_first_r;
  logic [NUM_W-1:0]       num_second_r;
  logic [CAL_W-1:0]       den_first_r;
  logic [CAL_W-1:0]       den_second_r;
  logic [PM_W-1:0]        quot_first;
  logic [PM_W-1:0]        quot_second;
  side_t                  side_last;
  logic [PM_W-1:0]        pm_first;
  logic [PM_W-1:0]        pm_second;
  logic [PM_W:0]          pm_sum;
  logic [PM_W-1:0]        pm_dist;
  out_item_t              out_data_r;
  out_item_t              out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_first_r   <= RST_CAL_LOW_FIRST;
      cal_high_first_r  <= RST_CAL_HIGH_FIRST;
      cal_low_second_r  <= RST_CAL_LOW_SECOND;
      cal_high_second_r <= RST_CAL_HIGH_SECOND;
      min_channel_gap_r <= RST_MIN_CHANNEL_GAP;
      max_percent_gap_r <= RST_MAX_PERCENT_GAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAL_LOW_FIRST:   cal_low_first_r   <= cfg_wdata;
        REG_CAL_HIGH_FIRST:  cal_high_first_r  <= cfg_wdata;
        REG_CAL_LOW_SECOND:  cal_low_second_r  <= cfg_wdata;
        REG_CAL_HIGH_SECOND: cal_high_second_r <= cfg_wdata;
        REG_MIN_CHANNEL_GAP: min_channel_gap_r <= cfg_wdata;
        REG_MAX_PERCENT_GAP: max_percent_gap_r <= cfg_wdata[PM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpsp_pipe_ctl #(
    .STAGES(PIPE_STAGES)
  ) u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .stage_en (stage_en)
  );

  dpsp_mv_conv #(
    .ADC_BITS(ADC_BITS)
  ) u_conv_first (
    .clk     (clk),
    .stage_en(stage_en[CONV_STAGES-1:0]),
    .raw     (in_data.raw_first),
    .mv      (mv_first)
  );

  dpsp_mv_conv #(
    .ADC_BITS(ADC_BITS)
  ) u_conv_second (
    .clk     (clk),
    .stage_en(stage_en[CONV_STAGES-1:0]),
    .raw     (in_data.raw_second),
    .mv      (mv_second)
  );

  assign prep_first  = chan_prep(mv_first, cal_low_first_r, cal_high_first_r);
  assign prep_second = chan_prep(mv_second, cal_low_second_r, cal_high_second_r);
  assign mv_dist     = (mv_first > mv_second) ? (mv_first - mv_second)
                                              : (mv_second - mv_first);

  always_comb begin
    side_nxt.mv_first   = mv_first;
    side_nxt.mv_second  = mv_second;
    side_nxt.sel_first  = prep_first.sel;
    side_nxt.sel_second = prep_second.sel;
    side_nxt.ok = !((CAL_W'(mv_first) < GND_LIM_FIRST) ||
                    (CAL_W'(mv_second) < GND_LIM_SECOND) ||
                    (CAL_W'(mv_first) > SUP_LIM_FIRST) ||
                    (CAL_W'(mv_second) > SUP_LIM_SECOND) ||
                    (CAL_W'(mv_dist) < min_channel_gap_r) ||
                    prep_first.window_bad ||
                    prep_second.window_bad);
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_PREP]) begin
      num_first_r  <= prep_first.num;
      den_first_r  <= prep_first.den;
      num_second_r <= prep_second.num;
      den_second_r <= prep_second.den;
      side_r[0]    <= side_nxt;
    end
    for (int i = 1; i < SIDE_N; i++) begin
      if (stage_en[ST_PREP + i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  dpsp_div #(
    .NUM_W(NUM_W),
    .DEN_W(CAL_W),
    .Q_W  (DIV_STAGES)
  ) u_div_first (
    .clk     (clk),
    .stage_en(stage_en[ST_DIV0 +: DIV_STAGES]),
    .num     (num_first_r),
    .den     (den_first_r),
    .quot    (quot_first)
  );

  dpsp_div #(
    .NUM_W(NUM_W),
    .DEN_W(CAL_W),
    .Q_W  (DIV_STAGES)
  ) u_div_second (
    .clk     (clk),
    .stage_en(stage_en[ST_DIV0 +: DIV_STAGES]),
    .num     (num_second_r),
    .den     (den_second_r),
    .quot    (quot_second)
  );

  assign side_last = side_r[SIDE_N-1];

  always_comb begin
    unique case (side_last.sel_first)
      PM_ZERO: pm_first = '0;
      PM_FULL: pm_first = PERMILLE_FULL;
      default: pm_first = quot_first;
    endcase
    unique case (side_last.sel_second)
      PM_ZERO: pm_second = '0;
      PM_FULL: pm_second = PERMILLE_FULL;
      default: pm_second = quot_second;
    endcase
  end

  assign pm_sum  = (PM_W+1)'(pm_first) + (PM_W+1)'(pm_second);
  assign pm_dist = (pm_first > pm_second) ? (pm_first - pm_second) : (pm_second - pm_first);

  always_comb begin
    out_data_nxt.millivolts_first  = side_last.mv_first;
    out_data_nxt.millivolts_second = side_last.mv_second;
    out_data_nxt.permille_first    = pm_first;
    out_data_nxt.permille_second   = pm_second;
    out_data_nxt.pedal_position    = pm_sum[PM_W:1];
    out_data_nxt.plausible         = side_last.ok && (pm_dist <= max_percent_gap_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule
